@@ rtl/core/ccr_pkg.sv @@
`timescale 1ns / 1ps

package ccr_pkg;

  localparam int MAX_RESULTS = 64;
  localparam int SCORE_W     = 31;
  localparam int COL_W       = 6;
  localparam int ROW_W       = 6;
  localparam int LINE_CNT_W  = 7;

  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};
  localparam logic [SCORE_W-1:0] SCORE_ONE = {{(SCORE_W-1){1'b0}}, 1'b1};

  typedef enum logic [1:0] {
    OP_LINE   = 2'd0,
    OP_CLOSE  = 2'd1,
    OP_FINISH = 2'd2
  } opcode_t;

  typedef struct packed {
    opcode_t                opcode;
    logic [COL_W-1:0]       column;
    logic [ROW_W-1:0]       row;
    logic [LINE_CNT_W-1:0]  remaining_ones;
    logic [LINE_CNT_W-1:0]  unknown_count;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]   out_row;
    logic [COL_W-1:0]   out_column;
    logic [SCORE_W-1:0] ones_score;
    logic [SCORE_W-1:0] zeros_score;
    logic               preferred;
    logic [SCORE_W-1:0] confidence;
    logic               valid_res;
    logic               last;
  } out_item_t;

  // one stored cell of the row
  typedef struct packed {
    logic [COL_W-1:0]   column;
    logic [SCORE_W-1:0] ones;
    logic [SCORE_W-1:0] zeros;
    logic [SCORE_W-1:0] conf;
    logic               pref;
  } entry_t;

  typedef struct packed {
    logic start;    // take a line factor pair
    logic restart;  // scores back to one
  } acc_ctrl_t;

endpackage

@@ rtl/core/ccr_acc.sv @@
`timescale 1ns / 1ps

module ccr_acc
  import ccr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  acc_ctrl_t             ctrl,
  input  logic [LINE_CNT_W-1:0] rem,
  input  logic [LINE_CNT_W-1:0] unk,
  output logic [SCORE_W-1:0]    ones,
  output logic [SCORE_W-1:0]    zeros,
  output logic                  busy
);

  localparam int PROD_W = SCORE_W + LINE_CNT_W;

  typedef enum logic [2:0] {
    A_IDLE  = 3'b001,
    A_ONES  = 3'b010,
    A_ZEROS = 3'b100
  } acc_state_t;

  acc_state_t              state_r, state_nxt;
  logic [SCORE_W-1:0]      ones_r, ones_nxt;
  logic [SCORE_W-1:0]      zeros_r, zeros_nxt;
  logic [LINE_CNT_W-1:0]   f1_r, f1_nxt;
  logic [LINE_CNT_W-1:0]   f0_r, f0_nxt;
  logic [SCORE_W-1:0]      mul_a;
  logic [LINE_CNT_W-1:0]   mul_b;
  logic [PROD_W-1:0]       prod;
  logic [SCORE_W-1:0]      prod_sat;

  // one shared multiplier, ones pass then zeros pass
  assign mul_a    = (state_r == A_ZEROS) ? zeros_r : ones_r;
  assign mul_b    = (state_r == A_ZEROS) ? f0_r : f1_r;
  assign prod     = {{LINE_CNT_W{1'b0}}, mul_a} * {{SCORE_W{1'b0}}, mul_b};
  assign prod_sat = (|prod[PROD_W-1:SCORE_W]) ? SCORE_MAX : prod[SCORE_W-1:0];

  always_comb begin
    state_nxt = state_r;
    ones_nxt  = ones_r;
    zeros_nxt = zeros_r;
    f1_nxt    = f1_r;
    f0_nxt    = f0_r;
    unique case (state_r)
      A_IDLE: begin
        if (ctrl.restart) begin
          ones_nxt  = SCORE_ONE;
          zeros_nxt = SCORE_ONE;
        end else if (ctrl.start) begin
          f1_nxt    = rem;
          f0_nxt    = (rem > unk) ? '0 : unk - rem;
          state_nxt = A_ONES;
        end
      end
      A_ONES: begin
        ones_nxt  = prod_sat;
        state_nxt = A_ZEROS;
      end
      A_ZEROS: begin
        zeros_nxt = prod_sat;
        state_nxt = A_IDLE;
      end
      default: state_nxt = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      ones_r  <= SCORE_ONE;
      zeros_r <= SCORE_ONE;
    end else begin
      state_r <= state_nxt;
      ones_r  <= ones_nxt;
      zeros_r <= zeros_nxt;
    end
    f1_r <= f1_nxt;
    f0_r <= f0_nxt;
  end

  assign ones  = ones_r;
  assign zeros = zeros_r;
  assign busy  = (state_r != A_IDLE);

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.start || ctrl.restart) |-> (state_r == A_IDLE))
    else $error("accumulator command while busy");

endmodule

@@ rtl/core/ccr_store.sv @@
`timescale 1ns / 1ps

module ccr_store
  import ccr_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6
)
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/core/cell_confidence_ranker_core.sv @@
`timescale 1ns / 1ps
// Cell confidence ranker.
// Input channel (in_valid/in_ready/in_data) takes one command per transfer:
//   line factor - scales the ones and zeros scores (two passes of
//                 the shared 31x7 saturating multiplier)
//   close cell  - stores scores with the column unless full, restarts scores
//   finish row  - emits the stored cells, highest confidence first, equal
//                 confidence in store order; an empty row gives one result
//                 with valid_res low.
// Result channel (out_valid/out_ready/out_data) carries one cell per transfer,
// last set on the final one of the row.
// Each result of a finished row is picked by a full selection scan over the
// cell store, one entry a cycle through its single registered read port.
// in_ready is low while a command is in progress, including while a result
// waits; a stalled receiver holds the block with the result unchanged.
// Reset (rst_n, synchronous) empties the row and sets both scores to one.

module cell_confidence_ranker_core
  import ccr_pkg::*;
#(
  parameter int ROW_CELLS = 64
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int CAP   = (ROW_CELLS < MAX_RESULTS) ? ROW_CELLS : MAX_RESULTS;
  localparam int IDX_W = $clog2(CAP);
  localparam int CNT_W = $clog2(CAP + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAP);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CNT_W-1:0]   cnt_last;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [CNT_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]   issue_r, issue_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               rd_last_r, rd_last_nxt;
  logic               best_ok_r, best_ok_nxt;
  entry_t             best_r, best_nxt;
  logic [IDX_W-1:0]   best_idx_r, best_idx_nxt;
  logic [CAP-1:0]     emitted_r, emitted_nxt;
  out_item_t          out_r, out_nxt;

  acc_ctrl_t          acc_ctrl;
  logic [SCORE_W-1:0] ones_acc;
  logic [SCORE_W-1:0] zeros_acc;
  logic               acc_busy;

  logic               wr_en;
  entry_t             wr_data;
  logic               rd_en;
  entry_t             rd_data;

  logic               take;
  entry_t             sel;
  logic [IDX_W-1:0]   sel_idx;

  ccr_acc u_acc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (acc_ctrl),
    .rem   (in_data.remaining_ones),
    .unk   (in_data.unknown_count),
    .ones  (ones_acc),
    .zeros (zeros_acc),
    .busy  (acc_busy)
  );

  ccr_store #(
    .DEPTH (CAP),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (issue_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign wr_data.column = in_data.column;
  assign wr_data.ones   = ones_acc;
  assign wr_data.zeros  = zeros_acc;
  assign wr_data.pref   = ones_acc > zeros_acc;
  assign wr_data.conf   = (ones_acc >= zeros_acc) ? ones_acc - zeros_acc
                                                  : zeros_acc - ones_acc;

  assign cnt_last = cnt_r - 1'b1;

  // strictly greater keeps the earliest stored cell on ties
  assign take    = !emitted_r[rd_idx_r] && (!best_ok_r || (rd_data.conf > best_r.conf));
  assign sel     = take ? rd_data : best_r;
  assign sel_idx = take ? rd_idx_r : best_idx_r;

  assign in_ready  = (state_r == ST_IDLE) && !acc_busy;
  assign out_valid = (state_r == ST_OUT);
  assign out_data  = out_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    row_nxt      = row_r;
    pos_nxt      = pos_r;
    issue_nxt    = issue_r;
    rd_vld_nxt   = 1'b0;
    rd_idx_nxt   = rd_idx_r;
    rd_last_nxt  = rd_last_r;
    best_ok_nxt  = best_ok_r;
    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    emitted_nxt  = emitted_r;
    out_nxt      = out_r;
    acc_ctrl     = '0;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          case (in_data.opcode)
            OP_LINE: begin
              acc_ctrl.start = 1'b1;
            end
            OP_CLOSE: begin
              acc_ctrl.restart = 1'b1;
              if (cnt_r < CAP_CNT) begin
                wr_en   = 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            OP_FINISH: begin
              acc_ctrl.restart = 1'b1;
              row_nxt          = in_data.row;
              if (cnt_r == '0) begin
                out_nxt         = '0;
                out_nxt.out_row = in_data.row;
                out_nxt.last    = 1'b1;
                state_nxt       = ST_OUT;
              end else begin
                issue_nxt   = '0;
                pos_nxt     = '0;
                emitted_nxt = '0;
                best_ok_nxt = 1'b0;
                state_nxt   = ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (issue_r < cnt_r) begin
          rd_en       = 1'b1;
          rd_vld_nxt  = 1'b1;
          rd_idx_nxt  = issue_r[IDX_W-1:0];
          rd_last_nxt = (issue_r == cnt_last);
          issue_nxt   = issue_r + 1'b1;
        end
        if (rd_vld_r) begin
          if (rd_last_r) begin
            out_nxt.out_row      = row_r;
            out_nxt.out_column   = sel.column;
            out_nxt.ones_score   = sel.ones;
            out_nxt.zeros_score  = sel.zeros;
            out_nxt.preferred    = sel.pref;
            out_nxt.confidence   = sel.conf;
            out_nxt.valid_res    = 1'b1;
            out_nxt.last         = (pos_r == cnt_last);
            emitted_nxt[sel_idx] = 1'b1;
            best_ok_nxt          = 1'b0;
            state_nxt            = ST_OUT;
          end else begin
            best_nxt     = sel;
            best_idx_nxt = sel_idx;
            best_ok_nxt  = best_ok_r || take;
          end
        end
      end
      ST_OUT: begin
        if (out_ready) begin
          if (out_r.last) begin
            cnt_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            issue_nxt = '0;
            pos_nxt   = pos_r + 1'b1;
            state_nxt = ST_SCAN;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      pos_r     <= '0;
      issue_r   <= '0;
      rd_vld_r  <= 1'b0;
      best_ok_r <= 1'b0;
      emitted_r <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      pos_r     <= pos_nxt;
      issue_r   <= issue_nxt;
      rd_vld_r  <= rd_vld_nxt;
      best_ok_r <= best_ok_nxt;
      emitted_r <= emitted_nxt;
    end
    row_r      <= row_nxt;
    rd_idx_r   <= rd_idx_nxt;
    rd_last_r  <= rd_last_nxt;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    out_r      <= out_nxt;
  end

  a_no_input_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while a result is pending");

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_CNT)
    else $error("cell count beyond store capacity");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_r.last) |=> (state_r == ST_IDLE && cnt_r == '0))
    else $error("row not closed after last transfer");

  a_emitted_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_r.valid_res) |-> ($countones(emitted_r) == int'(pos_r) + 1))
    else $error("emitted cells out of step with result position");

  a_read_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> ({1'b0, rd_idx_r} < {1'b0, cnt_r}))
    else $error("store read beyond filled cells");

endmodule

@@ tb/ccr_checker.sv @@
`timescale 1ns / 1ps

module ccr_checker
  import ccr_pkg::*;
#(
  parameter int ROW_CELLS = 64
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending,
  output int        cells_ranked,
  output int        rows_ranked,
  output int        cells_dropped
);

  localparam int ROW_CAP = (ROW_CELLS < MAX_RESULTS) ? ROW_CELLS : MAX_RESULTS;

  logic [SCORE_W-1:0] ones_acc;
  logic [SCORE_W-1:0] zeros_acc;
  logic [SCORE_W-1:0] row_ones  [MAX_RESULTS];
  logic [SCORE_W-1:0] row_zeros [MAX_RESULTS];
  logic [COL_W-1:0]   row_col   [MAX_RESULTS];
  int                 row_fill;
  out_item_t          ranked_q[$];

  function automatic logic [SCORE_W-1:0] scale_sat(input logic [SCORE_W-1:0] acc,
                                                   input logic [LINE_CNT_W-1:0] factor);
    logic [SCORE_W+LINE_CNT_W-1:0] prod;
    prod = {{LINE_CNT_W{1'b0}}, acc} * {{SCORE_W{1'b0}}, factor};
    return (prod > {{LINE_CNT_W{1'b0}}, SCORE_MAX}) ? SCORE_MAX : prod[SCORE_W-1:0];
  endfunction

  // sort stored cells by descending |ones - zeros|, stable on store order
  function automatic void rank_row(input logic [ROW_W-1:0] row_idx);
    int                 order [MAX_RESULTS];
    logic [SCORE_W-1:0] conf  [MAX_RESULTS];
    int                 i;
    int                 j;
    int                 key;
    int                 k;
    out_item_t          res;
    if (row_fill == 0) begin
      res = '0;
      res.out_row = row_idx;
      res.last = 1'b1;
      ranked_q.insert(ranked_q.size(), res);
      return;
    end
    for (i = 0; i < row_fill; i++) begin
      conf[i] = (row_ones[i] > row_zeros[i]) ? row_ones[i] - row_zeros[i]
                                             : row_zeros[i] - row_ones[i];
      order[i] = i;
    end
    for (i = 1; i < row_fill; i++) begin
      key = order[i];
      j = i;
      while (j > 0 && conf[order[j-1]] < conf[key]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = key;
    end
    for (i = 0; i < row_fill; i++) begin
      k = order[i];
      res.out_row     = row_idx;
      res.out_column  = row_col[k];
      res.ones_score  = row_ones[k];
      res.zeros_score = row_zeros[k];
      res.preferred   = row_ones[k] > row_zeros[k];
      res.confidence  = conf[k];
      res.valid_res   = 1'b1;
      res.last        = (i == row_fill - 1);
      ranked_q.insert(ranked_q.size(), res);
    end
  endfunction

  function automatic void apply_command(input in_item_t c);
    logic [LINE_CNT_W-1:0] zero_factor;
    case (c.opcode)
      OP_LINE: begin
        zero_factor = (c.remaining_ones > c.unknown_count) ? '0
                    : c.unknown_count - c.remaining_ones;
        ones_acc  = scale_sat(ones_acc, c.remaining_ones);
        zeros_acc = scale_sat(zeros_acc, zero_factor);
      end
      OP_CLOSE: begin
        if (row_fill < ROW_CAP) begin
          row_ones[row_fill]  = ones_acc;
          row_zeros[row_fill] = zeros_acc;
          row_col[row_fill]   = c.column;
          row_fill++;
        end else begin
          cells_dropped++;
        end
        ones_acc  = SCORE_ONE;
        zeros_acc = SCORE_ONE;
      end
      OP_FINISH: begin
        rank_row(c.row);
        row_fill  = 0;
        ones_acc  = SCORE_ONE;
        zeros_acc = SCORE_ONE;
        rows_ranked++;
      end
      default: ;  // unused code, no effect
    endcase
  endfunction

  function automatic bit field_ok(input string name, input logic [SCORE_W-1:0] want,
                                  input logic [SCORE_W-1:0] seen);
    if (seen !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, seen);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void check_result(input out_item_t got);
    out_item_t want;
    bit        ok;
    if (ranked_q.size() == 0) begin
      $error("result with nothing expected: row %0d column %0d", got.out_row, got.out_column);
      fail_count++;
      return;
    end
    want = ranked_q.pop_front();
    ok = 1'b1;
    ok &= field_ok("out_row",     SCORE_W'(want.out_row),     SCORE_W'(got.out_row));
    ok &= field_ok("out_column",  SCORE_W'(want.out_column),  SCORE_W'(got.out_column));
    ok &= field_ok("ones_score",  want.ones_score,            got.ones_score);
    ok &= field_ok("zeros_score", want.zeros_score,           got.zeros_score);
    ok &= field_ok("preferred",   SCORE_W'(want.preferred),   SCORE_W'(got.preferred));
    ok &= field_ok("confidence",  want.confidence,            got.confidence);
    ok &= field_ok("valid_res",   SCORE_W'(want.valid_res),   SCORE_W'(got.valid_res));
    ok &= field_ok("last",        SCORE_W'(want.last),        SCORE_W'(got.last));
    if (!ok) fail_count++;
    cells_ranked++;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      ones_acc  = SCORE_ONE;
      zeros_acc = SCORE_ONE;
      row_fill  = 0;
      ranked_q.delete();
    end else begin
      // a result always belongs to an earlier command, so compare first
      if (out_valid && out_ready) check_result(out_data);
      if (in_valid && in_ready) apply_command(in_data);
    end
    pending = ranked_q.size();
  end

endmodule

@@ tb/tb_cell_confidence_ranker_core.sv @@
`timescale 1ns / 1ps

module tb_cell_confidence_ranker_core;
  import ccr_pkg::*;

  localparam int      ROW_CELLS   = 64;
  localparam int      CMD_TARGET  = 370;
  localparam int      CALM_FROM   = 300;
  localparam int      CYCLE_LIMIT = 500000;
  localparam int      DRAIN_WAIT  = 20;
  localparam opcode_t OP_UNUSED   = opcode_t'(2'd3);

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  int fail_count;
  int pending;
  int cells_ranked;
  int rows_ranked;
  int cells_dropped;

  int cmds_sent  = 0;
  int cycles     = 0;
  bit calm       = 1'b0;
  int ready_hold = 0;

  // line factors of the previous cell, replayed to force equal confidence
  logic [LINE_CNT_W-1:0] prev_rem [8];
  logic [LINE_CNT_W-1:0] prev_unk [8];
  int                    prev_lines = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cell_confidence_ranker_core #(.ROW_CELLS(ROW_CELLS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  ccr_checker #(.ROW_CELLS(ROW_CELLS)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .cells_ranked  (cells_ranked),
    .rows_ranked   (rows_ranked),
    .cells_dropped (cells_dropped)
  );

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver: stall and run bursts, always ready once calm
  always @(negedge clk) begin
    if (calm) begin
      out_ready = 1'b1;
    end else if (ready_hold > 0) begin
      ready_hold--;
    end else if ($urandom_range(0, 2) == 0) begin
      out_ready  = 1'b0;
      ready_hold = $urandom_range(0, 15);
    end else begin
      out_ready  = 1'b1;
      ready_hold = $urandom_range(0, 31);
    end
  end

  function automatic in_item_t junk_cmd();
    logic [31:0]                 rnd;
    logic [$bits(in_item_t)-1:0] raw;
    rnd = $urandom;
    raw = rnd[$bits(in_item_t)-1:0];
    return raw;
  endfunction

  // entered and left at a falling edge; valid stays up into the next call
  task automatic send_cmd(input in_item_t c);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = c;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    if (c.opcode != OP_UNUSED) cmds_sent++;
  endtask

  task automatic send_line(input logic [LINE_CNT_W-1:0] rem, input logic [LINE_CNT_W-1:0] unk);
    in_item_t c;
    c = junk_cmd();
    c.opcode = OP_LINE;
    c.remaining_ones = rem;
    c.unknown_count = unk;
    send_cmd(c);
  endtask

  task automatic send_close(input logic [COL_W-1:0] col);
    in_item_t c;
    c = junk_cmd();
    c.opcode = OP_CLOSE;
    c.column = col;
    send_cmd(c);
  endtask

  task automatic send_finish(input logic [ROW_W-1:0] row);
    in_item_t c;
    c = junk_cmd();
    c.opcode = OP_FINISH;
    c.row = row;
    send_cmd(c);
  endtask

  // mostly consistent lines, some with remaining above unknown, a few unbounded
  task automatic pick_line(output logic [LINE_CNT_W-1:0] rem,
                           output logic [LINE_CNT_W-1:0] unk);
    int k;
    k = $urandom_range(0, 19);
    unk = LINE_CNT_W'($urandom_range(0, 64));
    if (k < 14) begin
      rem = LINE_CNT_W'($urandom_range(0, unk));
    end else if (k < 18) begin
      rem = LINE_CNT_W'($urandom_range(0, 64));
    end else begin
      rem = LINE_CNT_W'($urandom_range(0, 127));
      unk = LINE_CNT_W'($urandom_range(0, 127));
    end
  endtask

  task automatic send_random_cell();
    int n;
    int k;
    int i;
    k = $urandom_range(0, 29);
    if (k < 6 && prev_lines > 0) begin
      n = prev_lines;
    end else begin
      if (k < 8) n = 0;
      else if (k < 9) n = $urandom_range(5, 8);  // long products, may saturate
      else n = $urandom_range(1, 3);
      for (i = 0; i < n; i++) pick_line(prev_rem[i], prev_unk[i]);
      prev_lines = n;
    end
    for (i = 0; i < n; i++) send_line(prev_rem[i], prev_unk[i]);
    send_close(COL_W'($urandom_range(0, 63)));
  endtask

  task automatic send_random_row();
    int                    k;
    int                    cells;
    logic [LINE_CNT_W-1:0] rem;
    logic [LINE_CNT_W-1:0] unk;
    in_item_t              c;
    k = $urandom_range(0, 99);
    if (k < 8) begin
      repeat ($urandom_range(1, 6)) send_cmd(junk_cmd());
    end else if (k < 12) begin
      send_finish(ROW_W'($urandom_range(0, 63)));
    end else begin
      cells = (k < 14) ? $urandom_range(30, 70) : $urandom_range(1, 6);
      repeat (cells) send_random_cell();
      if ($urandom_range(0, 9) == 0) begin
        // scores left open at finish, plus a stray unused code
        pick_line(rem, unk);
        send_line(rem, unk);
        c = junk_cmd();
        c.opcode = OP_UNUSED;
        send_cmd(c);
      end
      send_finish(ROW_W'($urandom_range(0, 63)));
    end
  endtask

  initial begin
    logic [LINE_CNT_W-1:0] rem;
    logic [LINE_CNT_W-1:0] unk;
    in_item_t              c;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // directed: empty row, zero and extreme factors, saturation, ties
    send_finish(6'd63);
    send_line(7'd0, 7'd0);
    send_close(6'd0);
    send_line(7'd127, 7'd127);
    send_close(6'd63);
    repeat (6) send_line(7'd64, 7'd127);
    send_close(6'd1);
    send_line(7'd65, 7'd10);
    send_line(7'd3, 7'd127);
    send_close(6'd42);
    send_close(6'd21);
    send_line(7'd5, 7'd9);
    send_finish(6'd0);
    c = '1;
    send_cmd(c);
    send_close(6'd7);
    send_finish(6'd42);

    // one row past the store capacity
    repeat (MAX_RESULTS + 3) begin
      if ($urandom_range(0, 1) == 1) begin
        pick_line(rem, unk);
        send_line(rem, unk);
      end
      send_close(COL_W'($urandom_range(0, 63)));
    end
    send_finish(ROW_W'($urandom_range(0, 63)));

    while (cmds_sent < CMD_TARGET) begin
      calm = (cmds_sent >= CALM_FROM);
      send_random_row();
    end
    in_valid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d commands over %0d finished rows; %0d ranked results checked.",
             cmds_sent, rows_ranked, cells_ranked);
    $display("Closes dropped on a full row: %0d.", cells_dropped);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/ccr_pkg.sv
rtl/core/ccr_acc.sv
rtl/core/ccr_store.sv
rtl/core/cell_confidence_ranker_core.sv
tb/ccr_checker.sv
tb/tb_cell_confidence_ranker_core.sv
